/* design/fcm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the feedback comb filter with dry/wet mix.
// Used by fcm_ctrl, fcm_dp and feedback_comb_filter_mix; depends on nothing else.
package fcm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int MUL_W    = 18;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [GAIN_W:0] Q15_ONE = 17'd32768;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_POL     = 3'd4;

	localparam logic [GAIN_W-1:0] RST_DELAY_LENGTH   = 16'd441;
	localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN  = 16'd22938;
	localparam logic [GAIN_W-1:0] RST_RESONANCE_GAIN = 16'd16384;
	localparam logic [GAIN_W-1:0] RST_MIX_GAIN       = 16'd16384;

	localparam logic signed [PROD_W-1:0] SAMPLE_MAX = 36'sd32767;
	localparam logic signed [PROD_W-1:0] SAMPLE_MIN = -36'sd32768;
	localparam logic signed [PROD_W-1:0] ROUND_Q15  = 36'sd16384;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [GAIN_W-1:0] delay_length;
		logic [GAIN_W-1:0] feedback_gain;
		logic [GAIN_W-1:0] resonance_gain;
		logic [GAIN_W-1:0] mix_gain;
		logic              invert_polarity;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FB,
		ST_DRY,
		ST_WET,
		ST_PASS
	} fcm_state_t;

	typedef enum logic [1:0] {
		MUL_FB,
		MUL_DRY,
		MUL_WET
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     step_fb;
		logic     step_dry;
		logic     load_wet;
		logic     load_pass;
		mul_sel_t mul_sel;
	} fcm_cmd_t;

	typedef struct packed {
		logic out_free;
	} fcm_sts_t;

	function automatic sample_t sat_sample(input logic signed [PROD_W-1:0] v);
		sample_t r;
		if (v > SAMPLE_MAX) begin
			r = sample_t'(SAMPLE_MAX[SAMPLE_W-1:0]);
		end else if (v < SAMPLE_MIN) begin
			r = sample_t'(SAMPLE_MIN[SAMPLE_W-1:0]);
		end else begin
			r = sample_t'(v[SAMPLE_W-1:0]);
		end
		return r;
	endfunction

	function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
		return ({1'b0, g} > Q15_ONE) ? Q15_ONE[GAIN_W-1:0] : g;
	endfunction

endpackage

/* design/fcm_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the comb filter: accept, feedback, dry product, wet product and output, or bypass to output.
// Depends on fcm_pkg; drives fcm_dp through the command struct.
module fcm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_bypass,
	output logic             in_ready,
	input  fcm_pkg::fcm_sts_t sts,
	output fcm_pkg::fcm_cmd_t cmd
);
	import fcm_pkg::*;

	fcm_state_t state_q;
	fcm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = in_bypass ? ST_PASS : ST_FB;
				end
			end
			ST_FB:  state_d = ST_DRY;
			ST_DRY: state_d = ST_WET;
			ST_WET: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_PASS: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd.load_in   = (state_q == ST_IDLE) && in_valid;
		cmd.step_fb   = (state_q == ST_FB);
		cmd.step_dry  = (state_q == ST_DRY);
		cmd.load_wet  = (state_q == ST_WET) && sts.out_free;
		cmd.load_pass = (state_q == ST_PASS) && sts.out_free;
		unique case (state_q)
			ST_DRY:  cmd.mul_sel = MUL_DRY;
			ST_WET:  cmd.mul_sel = MUL_WET;
			default: cmd.mul_sel = MUL_FB;
		endcase
	end

endmodule

/* design/fcm_dp.sv */
`timescale 1ns / 1ps
// Datapath: delay memory, write pointer, shared multiplier, accumulator and output register.
// Depends on fcm_pkg; sequenced by fcm_ctrl.
module fcm_dp #(
	parameter int DEPTH = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fcm_pkg::cfg_t      cfg,
	input  fcm_pkg::sample_t   audio_in,
	input  fcm_pkg::fcm_cmd_t  cmd,
	output fcm_pkg::fcm_sts_t  sts,
	output logic               out_valid,
	input  logic               out_ready,
	output fcm_pkg::sample_t   audio_out
);
	import fcm_pkg::*;

	localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = ((AW > GAIN_W) ? AW : GAIN_W) + 1;
	localparam logic [CW-1:0] DMAX = CW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	sample_t mem [DEPTH];

	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	sample_t       x_q;
	sample_t       rd_q;
	logic          rd_ok_q;
	logic [GAIN_W-1:0] eff_q;
	logic signed [PROD_W-1:0] acc_q;
	logic          out_valid_q;
	sample_t       out_q;

	logic [GAIN_W-1:0] fb_c, res_c, mix_c;
	logic [2*GAIN_W-1:0] eff_prod;
	logic [CW-1:0] dl_ext, d_c;
	logic [AW-1:0] d_a, rp;
	logic [AW:0]   rp_wrap;
	sample_t       delayed;
	logic signed [SAMPLE_W:0] comb;
	logic [GAIN_W:0] dry_gain;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] fb_sum, wet_sum;
	sample_t store_val, wet_val;

	// gains and effective feedback
	always_comb begin
		fb_c     = clamp_gain(cfg.feedback_gain);
		res_c    = clamp_gain(cfg.resonance_gain);
		mix_c    = clamp_gain(cfg.mix_gain);
		eff_prod = (2 * GAIN_W)'(fb_c) * (2 * GAIN_W)'(Q15_ONE + {1'b0, res_c})
			+ (2 * GAIN_W)'(Q15_ONE);
		dry_gain = Q15_ONE - {1'b0, mix_c};
	end

	// read address from the clamped delay
	always_comb begin
		dl_ext = CW'(cfg.delay_length);
		if (dl_ext == '0) begin
			d_c = CW'(1);
		end else if (dl_ext > DMAX) begin
			d_c = DMAX;
		end else begin
			d_c = dl_ext;
		end
		d_a     = d_c[AW-1:0];
		rp_wrap = {1'b0, wp_q} + DEPTH_X - {1'b0, d_a};
		rp      = (wp_q >= d_a) ? (wp_q - d_a) : rp_wrap[AW-1:0];
	end

	always_comb begin
		delayed = rd_ok_q ? rd_q : '0;
		comb    = cfg.invert_polarity
			? ((SAMPLE_W + 1)'(x_q) - (SAMPLE_W + 1)'(delayed))
			: ((SAMPLE_W + 1)'(x_q) + (SAMPLE_W + 1)'(delayed));
		unique case (cmd.mul_sel)
			MUL_DRY: begin
				mul_a = MUL_W'(x_q);
				mul_b = signed'({1'b0, dry_gain});
			end
			MUL_WET: begin
				mul_a = MUL_W'(comb);
				mul_b = signed'({2'b00, mix_c});
			end
			default: begin
				mul_a = MUL_W'(delayed);
				mul_b = signed'({2'b00, eff_q});
			end
		endcase
		prod      = mul_a * mul_b;
		fb_sum    = ((prod + ROUND_Q15) >>> 15) + PROD_W'(x_q);
		store_val = sat_sample(fb_sum);
		wet_sum   = (acc_q + prod + ROUND_Q15) >>> 15;
		wet_val   = sat_sample(wet_sum);
	end

	// delay memory: read on accept, write on the feedback step
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			rd_q <= mem[rp];
		end
		if (cmd.step_fb) begin
			mem[wp_q] <= store_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q <= audio_in;
		end
		if (cmd.step_dry) begin
			acc_q <= prod;
		end
		if (cmd.load_wet) begin
			out_q <= wet_val;
		end else if (cmd.load_pass) begin
			out_q <= x_q;
		end
		eff_q <= eff_prod[2*GAIN_W-1:GAIN_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				// entries below the pointer, or all once it has wrapped, hold written data
				rd_ok_q <= wrapped_q || (rp < wp_q);
			end
			if (cmd.step_fb) begin
				if (wp_q == LAST_PTR) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
			if (cmd.load_wet || cmd.load_pass) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign audio_out    = out_q;

endmodule

/* design/feedback_comb_filter_mix.sv */
`timescale 1ns / 1ps
// Top level of the feedback comb filter with dry/wet mix: configuration registers,
// sequencer and datapath. Depends on fcm_pkg, fcm_ctrl and fcm_dp.
//
//  channel  direction  signals                         word
//  s_       in         s_tvalid s_tready s_tdata s_tuser  audio_in, bypass
//  m_       out        m_tvalid m_tready m_tdata          audio_out
//  cfg_     in         cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// A filtered word passes these steps from acceptance to the output register: accept and
// read the delay memory, feedback multiply and memory write, dry product, wet product.
// All three products share one multiplier; a bypassed word goes from acceptance straight
// to the output register. Reset clears pointer and control state at once: no clearing pass
// runs, a fill mark makes unwritten memory entries read as zero. A stalled output holds the
// sequencer in its wet or pass state until the word is taken; no input is taken meanwhile.
module feedback_comb_filter_mix #(
	parameter int DEPTH = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [15:0]            s_tdata,    // [15:0] audio_in
	input  logic                   s_tuser,    // [0] bypass
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,    // [15:0] audio_out
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [fcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]            cfg_data
);
	import fcm_pkg::*;

	cfg_t     cfg_q;
	fcm_cmd_t cmd;
	fcm_sts_t sts;
	sample_t  audio_out;

	// configuration writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_length    <= RST_DELAY_LENGTH;
			cfg_q.feedback_gain   <= RST_FEEDBACK_GAIN;
			cfg_q.resonance_gain  <= RST_RESONANCE_GAIN;
			cfg_q.mix_gain        <= RST_MIX_GAIN;
			cfg_q.invert_polarity <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DELAY_LENGTH:   cfg_q.delay_length    <= cfg_data;
				CFG_FEEDBACK_GAIN:  cfg_q.feedback_gain   <= cfg_data;
				CFG_RESONANCE_GAIN: cfg_q.resonance_gain  <= cfg_data;
				CFG_MIX_GAIN:       cfg_q.mix_gain        <= cfg_data;
				CFG_INVERT_POL:     cfg_q.invert_polarity <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer: one word at a time
	fcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_bypass (s_tuser),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: delay memory, shared multiplier, output register
	fcm_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.audio_in  (sample_t'(s_tdata)),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.audio_out (audio_out)
	);

	assign m_tdata = audio_out;

endmodule
